[rtl/core/lpc_pkg.sv]
// Shared constants, codes and types of the two-channel lid position controller.
package lpc_pkg;

    localparam int ADC_BITS_DEF = 10;
    localparam int PWM_BITS_DEF = 8;

    localparam int POS_W   = 10;
    localparam int CFG_W   = 10;
    localparam int CFG_A_W = 2;
    localparam int TOL_W   = 10;
    localparam int LIM_W   = 8;
    localparam int DB_W    = 7;
    localparam int SPD_W   = 8;
    localparam int PCT_W   = 7;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_FIND = 2'd1;
    localparam logic [1:0] OP_MOVE = 2'd2;

    localparam logic [1:0] CH_RIGHT = 2'd0;
    localparam logic [1:0] CH_LEFT  = 2'd1;
    localparam logic [1:0] CH_BOTH  = 2'd2;
    localparam logic [1:0] CH_NONE  = 2'd3;

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_FIND = 2'd1;
    localparam logic [1:0] MODE_MOVE = 2'd2;

    localparam logic [CFG_A_W-1:0] REG_TOL   = 2'd0;
    localparam logic [CFG_A_W-1:0] REG_LIMIT = 2'd1;
    localparam logic [CFG_A_W-1:0] REG_DBAND = 2'd2;
    localparam logic [CFG_A_W-1:0] REG_SPEED = 2'd3;

    localparam logic [TOL_W-1:0] TOL_RST   = 10'd3;
    localparam logic [LIM_W-1:0] LIMIT_RST = 8'd5;
    localparam logic [DB_W-1:0]  DBAND_RST = 7'd10;
    localparam logic [SPD_W-1:0] SPEED_RST = 8'd200;
    localparam logic [LIM_W-1:0] STILL_MAX = 8'd255;

    typedef struct packed {
        logic [1:0]       op;
        logic [1:0]       ch;
        logic             dir;
        logic [PCT_W-1:0] tgt;
        logic [SPD_W-1:0] spd;
    } t_cmd;

    typedef struct packed {
        logic busy;
        logic done;
        logic bad;
    } t_stat;

endpackage

[rtl/core/lpc_in_if.sv]
// Command and sample channel of the lid position controller.
interface lpc_in_if #(
    parameter int ADC_BITS = lpc_pkg::ADC_BITS_DEF
);
    import lpc_pkg::*;

    logic                valid;
    logic                ready;
    logic [1:0]          operation;
    logic [1:0]          channel;
    logic                direction;
    logic [PCT_W-1:0]    target_percent;
    logic [SPD_W-1:0]    drive_speed;
    logic [ADC_BITS-1:0] sample_right;
    logic [ADC_BITS-1:0] sample_left;

    modport source (
        output valid, operation, channel, direction, target_percent, drive_speed,
               sample_right, sample_left,
        input  ready
    );
    modport sink (
        input  valid, operation, channel, direction, target_percent, drive_speed,
               sample_right, sample_left,
        output ready
    );
endinterface

[rtl/core/lpc_out_if.sv]
// Result channel of the lid position controller.
interface lpc_out_if #(
    parameter int ADC_BITS = lpc_pkg::ADC_BITS_DEF,
    parameter int PWM_BITS = lpc_pkg::PWM_BITS_DEF
);
    import lpc_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [PWM_BITS-1:0]     right_up_duty;
    logic [PWM_BITS-1:0]     right_down_duty;
    logic [PWM_BITS-1:0]     left_up_duty;
    logic [PWM_BITS-1:0]     left_down_duty;
    logic                    busy_res;
    logic                    job_done;
    logic [ADC_BITS-1:0]     found_limit;
    logic signed [POS_W-1:0] position_right;
    logic signed [POS_W-1:0] position_left;
    logic                    bad_command;

    modport source (
        output valid, right_up_duty, right_down_duty, left_up_duty, left_down_duty,
               busy_res, job_done, found_limit, position_right, position_left,
               bad_command,
        input  ready
    );
    modport sink (
        input  valid, right_up_duty, right_down_duty, left_up_duty, left_down_duty,
               busy_res, job_done, found_limit, position_right, position_left,
               bad_command,
        output ready
    );
endinterface

[rtl/core/lpc_map.sv]
// Sample to percent mapping unit built round a one-bit-per-cycle restoring divider.
module lpc_map #(
    parameter int ADC_BITS = lpc_pkg::ADC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [ADC_BITS-1:0]             i_sample,
    input  logic [ADC_BITS-1:0]             i_lo,
    input  logic [ADC_BITS-1:0]             i_hi,
    output logic                            o_done,
    output logic signed [lpc_pkg::POS_W-1:0] o_pos
);
    import lpc_pkg::*;

    localparam int QW  = ADC_BITS + 7;
    localparam int CW  = $clog2(QW + 1);

    localparam logic [1:0] M_IDLE = 2'd0;
    localparam logic [1:0] M_RUN  = 2'd1;
    localparam logic [1:0] M_FIN  = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [QW-1:0]       r_q, n_q;
    logic [ADC_BITS-1:0] r_rem, n_rem;
    logic [ADC_BITS-1:0] r_dvs, n_dvs;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic                r_neg, n_neg;
    logic                r_zero, n_zero;

    logic [ADC_BITS-1:0] num_d;
    logic [QW-1:0]       num_x;
    logic [ADC_BITS:0]   rem_sh;
    logic [ADC_BITS:0]   rem_sub;

    always_comb begin
        num_d   = (i_sample >= i_lo) ? (i_sample - i_lo) : (i_lo - i_sample);
        num_x   = QW'(num_d);
        rem_sh  = {r_rem, r_q[QW-1]};
        rem_sub = rem_sh - {1'b0, r_dvs};

        n_state = r_state;
        n_q     = r_q;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        n_cnt   = r_cnt;
        n_neg   = r_neg;
        n_zero  = r_zero;

        unique case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    n_q    = (num_x << 6) + (num_x << 5) + (num_x << 2);
                    n_rem  = '0;
                    n_dvs  = (i_hi >= i_lo) ? (i_hi - i_lo) : (i_lo - i_hi);
                    n_neg  = (i_sample < i_lo) ^ (i_hi < i_lo);
                    n_zero = (i_hi == i_lo);
                    n_cnt  = CW'(QW);
                    n_state = (i_hi == i_lo) ? M_FIN : M_RUN;
                end
            end
            M_RUN: begin
                if (rem_sh >= {1'b0, r_dvs}) begin
                    n_rem = rem_sub[ADC_BITS-1:0];
                    n_q   = {r_q[QW-2:0], 1'b1};
                end else begin
                    n_rem = rem_sh[ADC_BITS-1:0];
                    n_q   = {r_q[QW-2:0], 1'b0};
                end
                n_cnt = r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    n_state = M_FIN;
                end
            end
            M_FIN: begin
                n_state = M_IDLE;
            end
            default: begin
                n_state = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_q    <= n_q;
        r_rem  <= n_rem;
        r_dvs  <= n_dvs;
        r_cnt  <= n_cnt;
        r_neg  <= n_neg;
        r_zero <= n_zero;
    end

    assign o_done = (r_state == M_FIN);

    always_comb begin
        if (r_zero) begin
            o_pos = '0;
        end else if (r_neg) begin
            if (r_q > QW'(512)) begin
                o_pos = POS_W'(-512);
            end else begin
                o_pos = -$signed(r_q[POS_W-1:0]);
            end
        end else if (r_q > QW'(511)) begin
            o_pos = POS_W'(511);
        end else begin
            o_pos = $signed(r_q[POS_W-1:0]);
        end
    end

endmodule

[rtl/core/lpc_ctrl.sv]
// Configuration registers, job state and drive level update of the lid controller.
module lpc_ctrl #(
    parameter int ADC_BITS = lpc_pkg::ADC_BITS_DEF,
    parameter int PWM_BITS = lpc_pkg::PWM_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lpc_pkg::CFG_A_W-1:0]      i_cfg_index,
    input  logic [lpc_pkg::CFG_W-1:0]        i_cfg_data,
    input  logic                             i_upd,
    input  lpc_pkg::t_cmd                    i_cmd,
    input  logic [ADC_BITS-1:0]              i_smp_r,
    input  logic [ADC_BITS-1:0]              i_smp_l,
    input  logic signed [lpc_pkg::POS_W-1:0] i_pos_r,
    input  logic signed [lpc_pkg::POS_W-1:0] i_pos_l,
    output logic [ADC_BITS-1:0]              o_rlo,
    output logic [ADC_BITS-1:0]              o_rhi,
    output logic [ADC_BITS-1:0]              o_llo,
    output logic [ADC_BITS-1:0]              o_lhi,
    output logic [PWM_BITS-1:0]              o_lvl [4],
    output logic [ADC_BITS-1:0]              o_found,
    output lpc_pkg::t_stat                   o_stat
);
    import lpc_pkg::*;

    localparam int DW = ADC_BITS + TOL_W;

    logic [TOL_W-1:0]    r_tol;
    logic [LIM_W-1:0]    r_limit;
    logic [DB_W-1:0]     r_dband;
    logic [SPD_W-1:0]    r_sspd;

    logic [1:0]          r_mode, n_mode;
    logic [1:0]          r_chs, n_chs;
    logic                r_dir, n_dir;
    logic [ADC_BITS-1:0] r_prev, n_prev;
    logic [LIM_W-1:0]    r_still, n_still;
    logic [ADC_BITS-1:0] r_rlo, n_rlo;
    logic [ADC_BITS-1:0] r_rhi, n_rhi;
    logic [ADC_BITS-1:0] r_llo, n_llo;
    logic [ADC_BITS-1:0] r_lhi, n_lhi;
    logic [1:0]          r_cdone, n_cdone;
    logic [PCT_W-1:0]    r_tgt, n_tgt;
    logic [SPD_W-1:0]    r_mspd, n_mspd;
    logic [PWM_BITS-1:0] r_lvl [4];
    logic [PWM_BITS-1:0] n_lvl [4];
    logic                r_done, n_done;
    logic                r_bad, n_bad;
    logic [ADC_BITS-1:0] r_found, n_found;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol   <= TOL_RST;
            r_limit <= LIMIT_RST;
            r_dband <= DBAND_RST;
            r_sspd  <= SPEED_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_TOL:   r_tol   <= i_cfg_data[TOL_W-1:0];
                REG_LIMIT: r_limit <= i_cfg_data[LIM_W-1:0];
                REG_DBAND: r_dband <= i_cfg_data[DB_W-1:0];
                REG_SPEED: r_sspd  <= i_cfg_data[SPD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    logic                  c;
    logic [ADC_BITS-1:0]   s;
    logic [ADC_BITS-1:0]   diff;
    logic [LIM_W-1:0]      still_x;
    logic [1:0]            need;
    logic signed [10:0]    hi_t;
    logic signed [10:0]    lo_t;
    logic signed [10:0]    pos_x [2];

    always_comb begin
        n_mode  = r_mode;
        n_chs   = r_chs;
        n_dir   = r_dir;
        n_prev  = r_prev;
        n_still = r_still;
        n_rlo   = r_rlo;
        n_rhi   = r_rhi;
        n_llo   = r_llo;
        n_lhi   = r_lhi;
        n_cdone = r_cdone;
        n_tgt   = r_tgt;
        n_mspd  = r_mspd;
        n_lvl   = r_lvl;
        n_done  = 1'b0;
        n_bad   = 1'b0;
        n_found = '0;

        c       = r_chs[0];
        s       = c ? i_smp_l : i_smp_r;
        diff    = (s > r_prev) ? (s - r_prev) : (r_prev - s);
        still_x = (DW'(diff) <= DW'(r_tol))
                  ? ((r_still < STILL_MAX) ? (r_still + LIM_W'(1)) : r_still) : '0;
        need    = (r_chs == CH_BOTH) ? 2'b11 : (r_chs[0] ? 2'b10 : 2'b01);
        hi_t    = $signed({4'b0, r_tgt}) + $signed({4'b0, r_dband});
        lo_t    = $signed({4'b0, r_tgt}) - $signed({4'b0, r_dband});
        pos_x[0] = 11'(i_pos_r);
        pos_x[1] = 11'(i_pos_l);

        case (i_cmd.op)
            OP_FIND: begin
                if (i_cmd.ch == CH_BOTH || i_cmd.ch == CH_NONE) begin
                    n_bad = 1'b1;
                end else begin
                    n_mode  = MODE_FIND;
                    n_chs   = i_cmd.ch;
                    n_dir   = i_cmd.dir;
                    n_prev  = i_cmd.ch[0] ? i_smp_l : i_smp_r;
                    n_still = '0;
                    if (i_cmd.dir) begin
                        n_lvl[{i_cmd.ch[0], 1'b0}] = PWM_BITS'(r_sspd);
                        n_lvl[{i_cmd.ch[0], 1'b1}] = '0;
                    end else begin
                        n_lvl[{i_cmd.ch[0], 1'b0}] = '0;
                        n_lvl[{i_cmd.ch[0], 1'b1}] = PWM_BITS'(r_sspd);
                    end
                end
            end
            OP_MOVE: begin
                if (i_cmd.ch == CH_NONE) begin
                    n_bad = 1'b1;
                end else begin
                    n_mode  = MODE_MOVE;
                    n_chs   = i_cmd.ch;
                    n_tgt   = i_cmd.tgt;
                    n_mspd  = i_cmd.spd;
                    n_cdone = '0;
                end
            end
            OP_TICK: begin
                if (r_mode == MODE_FIND) begin
                    n_still = still_x;
                    n_prev  = s;
                    if (still_x >= r_limit) begin
                        n_lvl[{c, 1'b0}] = '0;
                        n_lvl[{c, 1'b1}] = '0;
                        case ({c, r_dir})
                            2'b00:   n_rlo = s;
                            2'b01:   n_rhi = s;
                            2'b10:   n_llo = s;
                            default: n_lhi = s;
                        endcase
                        n_found = s;
                        n_done  = 1'b1;
                        n_mode  = MODE_IDLE;
                    end
                end else if (r_mode == MODE_MOVE) begin
                    for (int k = 0; k < 2; k++) begin
                        if (need[k] && !r_cdone[k]) begin
                            if (pos_x[k] > hi_t) begin
                                n_lvl[2*k]   = '0;
                                n_lvl[2*k+1] = PWM_BITS'(r_mspd);
                            end else if (pos_x[k] < lo_t) begin
                                n_lvl[2*k]   = PWM_BITS'(r_mspd);
                                n_lvl[2*k+1] = '0;
                            end else begin
                                n_lvl[2*k]   = '1;
                                n_lvl[2*k+1] = '1;
                                n_cdone[k]   = 1'b1;
                            end
                        end
                    end
                    if ((n_cdone & need) == need) begin
                        n_done = 1'b1;
                        n_mode = MODE_IDLE;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_chs   <= '0;
            r_dir   <= 1'b0;
            r_prev  <= '0;
            r_still <= '0;
            r_rlo   <= '0;
            r_rhi   <= '0;
            r_llo   <= '0;
            r_lhi   <= '0;
            r_cdone <= '0;
            r_tgt   <= '0;
            r_mspd  <= '0;
            r_lvl   <= '{default: '0};
            r_done  <= 1'b0;
            r_bad   <= 1'b0;
            r_found <= '0;
        end else if (i_upd) begin
            r_mode  <= n_mode;
            r_chs   <= n_chs;
            r_dir   <= n_dir;
            r_prev  <= n_prev;
            r_still <= n_still;
            r_rlo   <= n_rlo;
            r_rhi   <= n_rhi;
            r_llo   <= n_llo;
            r_lhi   <= n_lhi;
            r_cdone <= n_cdone;
            r_tgt   <= n_tgt;
            r_mspd  <= n_mspd;
            r_lvl   <= n_lvl;
            r_done  <= n_done;
            r_bad   <= n_bad;
            r_found <= n_found;
        end
    end

    assign o_rlo       = r_rlo;
    assign o_rhi       = r_rhi;
    assign o_llo       = r_llo;
    assign o_lhi       = r_lhi;
    assign o_lvl       = r_lvl;
    assign o_found     = r_found;
    assign o_stat.busy = (r_mode != MODE_IDLE);
    assign o_stat.done = r_done;
    assign o_stat.bad  = r_bad;

endmodule

[rtl/core/two_channel_lid_position_controller.sv]
// Top level of the two-channel lid position controller with its item sequencer.
// Each command or sample beat runs through one shared mapping unit twice, first for the
// right channel and then for the left, and then updates the job state and drive levels
// in the update state. The mapping unit divides one quotient bit per cycle and skips the
// division for a channel whose end stops are equal. The block takes one beat at a time; a
// new beat is accepted while the previous result still waits in the output register.
// Duty outputs hold full scale on both drives to brake and zero on both drives to coast.
module two_channel_lid_position_controller #(
    parameter int ADC_BITS = lpc_pkg::ADC_BITS_DEF,
    parameter int PWM_BITS = lpc_pkg::PWM_BITS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [lpc_pkg::CFG_A_W-1:0] i_cfg_index,
    input  logic [lpc_pkg::CFG_W-1:0]   i_cfg_data,
    lpc_in_if.sink                      i_cmd,
    lpc_out_if.source                   o_res
);
    import lpc_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MAP0 = 3'd1;
    localparam logic [2:0] S_MAP1 = 3'd2;
    localparam logic [2:0] S_UPD  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    logic [2:0]              r_state, n_state;
    logic                    r_go, n_go;
    t_cmd                    r_cmd;
    logic [ADC_BITS-1:0]     r_smp_r;
    logic [ADC_BITS-1:0]     r_smp_l;
    logic signed [POS_W-1:0] r_pos_r;
    logic signed [POS_W-1:0] r_pos_l;

    logic                    r_out_valid, n_out_valid;
    logic [PWM_BITS-1:0]     r_out_lvl [4];
    t_stat                   r_out_stat;
    logic [ADC_BITS-1:0]     r_out_found;
    logic signed [POS_W-1:0] r_out_pos_r;
    logic signed [POS_W-1:0] r_out_pos_l;

    logic                    accept;
    logic                    load;
    logic                    map_done;
    logic signed [POS_W-1:0] map_pos;
    logic                    sel_l;
    logic [ADC_BITS-1:0]     rlo, rhi, llo, lhi;
    logic [PWM_BITS-1:0]     lvl [4];
    logic [ADC_BITS-1:0]     found;
    t_stat                   stat;

    assign i_cmd.ready = (r_state == S_IDLE);
    assign accept      = i_cmd.valid && i_cmd.ready;
    assign load        = (r_state == S_OUT) && (!r_out_valid || o_res.ready);
    assign sel_l       = (r_state == S_MAP1);

    lpc_map #(
        .ADC_BITS (ADC_BITS)
    ) u_map (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_go),
        .i_sample (sel_l ? r_smp_l : r_smp_r),
        .i_lo     (sel_l ? llo : rlo),
        .i_hi     (sel_l ? lhi : rhi),
        .o_done   (map_done),
        .o_pos    (map_pos)
    );

    lpc_ctrl #(
        .ADC_BITS (ADC_BITS),
        .PWM_BITS (PWM_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_upd       (r_state == S_UPD),
        .i_cmd       (r_cmd),
        .i_smp_r     (r_smp_r),
        .i_smp_l     (r_smp_l),
        .i_pos_r     (r_pos_r),
        .i_pos_l     (r_pos_l),
        .o_rlo       (rlo),
        .o_rhi       (rhi),
        .o_llo       (llo),
        .o_lhi       (lhi),
        .o_lvl       (lvl),
        .o_found     (found),
        .o_stat      (stat)
    );

    always_comb begin
        n_state = r_state;
        n_go    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_MAP0;
                    n_go    = 1'b1;
                end
            end
            S_MAP0: begin
                if (map_done) begin
                    n_state = S_MAP1;
                    n_go    = 1'b1;
                end
            end
            S_MAP1: begin
                if (map_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                if (load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_out_valid = r_out_valid;
        if (o_res.valid && o_res.ready) begin
            n_out_valid = 1'b0;
        end
        if (load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_go        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_go        <= n_go;
            r_out_valid <= n_out_valid;
        end
        if (accept) begin
            r_cmd.op  <= i_cmd.operation;
            r_cmd.ch  <= i_cmd.channel;
            r_cmd.dir <= i_cmd.direction;
            r_cmd.tgt <= i_cmd.target_percent;
            r_cmd.spd <= i_cmd.drive_speed;
            r_smp_r   <= i_cmd.sample_right;
            r_smp_l   <= i_cmd.sample_left;
        end
        if (map_done && !sel_l) begin
            r_pos_r <= map_pos;
        end
        if (map_done && sel_l) begin
            r_pos_l <= map_pos;
        end
        if (load) begin
            r_out_lvl   <= lvl;
            r_out_stat  <= stat;
            r_out_found <= found;
            r_out_pos_r <= r_pos_r;
            r_out_pos_l <= r_pos_l;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.right_up_duty   = r_out_lvl[0];
    assign o_res.right_down_duty = r_out_lvl[1];
    assign o_res.left_up_duty    = r_out_lvl[2];
    assign o_res.left_down_duty  = r_out_lvl[3];
    assign o_res.busy_res        = r_out_stat.busy;
    assign o_res.job_done        = r_out_stat.done;
    assign o_res.found_limit     = r_out_found;
    assign o_res.position_right  = r_out_pos_r;
    assign o_res.position_left   = r_out_pos_l;
    assign o_res.bad_command     = r_out_stat.bad;

endmodule

[sim/tb.sv]
// Self-checking testbench of the two-channel lid position controller.
module tb;
    import lpc_pkg::*;

    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam int         PWM_FULL = (1 << PWM_BITS_DEF) - 1;
    localparam int         ADC_TOP  = (1 << ADC_BITS_DEF) - 1;
    localparam int         ITEMS    = 1300;
    localparam int         PHASES   = 12;

    typedef struct {
        logic [1:0]       op;
        logic [1:0]       ch;
        logic             dir;
        logic [PCT_W-1:0] tgt;
        logic [SPD_W-1:0] spd;
        logic [9:0]       smp_r;
        logic [9:0]       smp_l;
    } t_lid_beat;

    typedef struct {
        int ru;
        int rd;
        int lu;
        int ld;
        int busy;
        int done;
        int found;
        int pos_r;
        int pos_l;
        int bad;
    } t_drive_report;

    class lid_drive_scoreboard;
        int            tol;
        int            still_limit;
        int            deadband;
        int            seek_speed;
        logic [1:0]    mode;
        logic [1:0]    job_ch;
        int            seek_dir;
        int            prev_smp;
        int            still_cnt;
        int            lower_stop[2];
        int            upper_stop[2];
        int            ch_done;
        int            move_tgt;
        int            move_spd;
        int            level[4];
        t_drive_report pending_drive[$];
        int            mismatches;

        function new();
            tol         = TOL_RST;
            still_limit = LIMIT_RST;
            deadband    = DBAND_RST;
            seek_speed  = SPEED_RST;
            mode        = MODE_IDLE;
            job_ch      = CH_RIGHT;
            seek_dir    = 0;
            prev_smp    = 0;
            still_cnt   = 0;
            lower_stop  = '{0, 0};
            upper_stop  = '{0, 0};
            ch_done     = 0;
            move_tgt    = 0;
            move_spd    = 0;
            level       = '{0, 0, 0, 0};
            mismatches  = 0;
        endfunction

        function void write_reg(logic [CFG_A_W-1:0] idx, logic [CFG_W-1:0] data);
            case (idx)
                REG_TOL:   tol         = data[TOL_W-1:0];
                REG_LIMIT: still_limit = data[LIM_W-1:0];
                REG_DBAND: deadband    = data[DB_W-1:0];
                REG_SPEED: seek_speed  = data[SPD_W-1:0];
                default: ;
            endcase
        endfunction

        function int map_percent(int smp, int lo, int hi);
            longint q;
            if (hi == lo)
                return 0;
            q = (longint'(smp - lo) * 100) / longint'(hi - lo);
            if (q > 511)
                q = 511;
            if (q < -512)
                q = -512;
            return int'(q);
        endfunction

        function void set_drive(int c, int up, int dn);
            level[c * 2]     = up;
            level[c * 2 + 1] = dn;
        endfunction

        function bit empty();
            return pending_drive.size() == 0;
        endfunction

        function void note_command(t_lid_beat b);
            t_drive_report r;
            int            smp[2];
            int            pos[2];
            int            c;
            int            s;
            int            diff;
            int            need;
            int            hi;
            int            lo;
            int            k;
            int            mask;
            smp[0]  = b.smp_r;
            smp[1]  = b.smp_l;
            pos[0]  = map_percent(smp[0], lower_stop[0], upper_stop[0]);
            pos[1]  = map_percent(smp[1], lower_stop[1], upper_stop[1]);
            r.done  = 0;
            r.found = 0;
            r.bad   = 0;
            if (b.op == OP_FIND) begin
                if (b.ch == CH_BOTH || b.ch == CH_NONE) begin
                    r.bad = 1;
                end else begin
                    mode      = MODE_FIND;
                    job_ch    = b.ch;
                    seek_dir  = b.dir;
                    prev_smp  = smp[b.ch[0]];
                    still_cnt = 0;
                    if (b.dir)
                        set_drive(b.ch[0], seek_speed, 0);
                    else
                        set_drive(b.ch[0], 0, seek_speed);
                end
            end else if (b.op == OP_MOVE) begin
                if (b.ch == CH_NONE) begin
                    r.bad = 1;
                end else begin
                    mode     = MODE_MOVE;
                    job_ch   = b.ch;
                    move_tgt = b.tgt;
                    move_spd = b.spd;
                    ch_done  = 0;
                end
            end else if (b.op == OP_TICK && mode == MODE_FIND) begin
                c    = job_ch[0];
                s    = smp[c];
                diff = (s > prev_smp) ? s - prev_smp : prev_smp - s;
                if (diff <= tol) begin
                    if (still_cnt < STILL_MAX)
                        still_cnt++;
                end else begin
                    still_cnt = 0;
                end
                prev_smp = s;
                if (still_cnt >= still_limit) begin
                    set_drive(c, 0, 0);
                    if (seek_dir)
                        upper_stop[c] = s;
                    else
                        lower_stop[c] = s;
                    r.found = s;
                    r.done  = 1;
                    mode    = MODE_IDLE;
                end
            end else if (b.op == OP_TICK && mode == MODE_MOVE) begin
                need = (job_ch == CH_BOTH) ? 3 : (1 << job_ch[0]);
                hi   = move_tgt + deadband;
                lo   = move_tgt - deadband;
                for (k = 0; k < 2; k++) begin
                    mask = 1 << k;
                    if ((need & mask) != 0 && (ch_done & mask) == 0) begin
                        if (pos[k] > hi) begin
                            set_drive(k, 0, move_spd);
                        end else if (pos[k] < lo) begin
                            set_drive(k, move_spd, 0);
                        end else begin
                            set_drive(k, PWM_FULL, PWM_FULL);
                            ch_done |= mask;
                        end
                    end
                end
                if ((ch_done & need) == need) begin
                    r.done = 1;
                    mode   = MODE_IDLE;
                end
            end
            r.ru    = level[0];
            r.rd    = level[1];
            r.lu    = level[2];
            r.ld    = level[3];
            r.busy  = (mode != MODE_IDLE);
            r.pos_r = pos[0];
            r.pos_l = pos[1];
            pending_drive.push_back(r);
        endfunction

        function void compare(string name, int want, int got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_drive(t_drive_report a);
            t_drive_report e;
            if (pending_drive.size() == 0) begin
                $error("result beat arrived with no command beat waiting");
                mismatches++;
                return;
            end
            e = pending_drive.pop_front();
            compare("right_up_duty", e.ru, a.ru);
            compare("right_down_duty", e.rd, a.rd);
            compare("left_up_duty", e.lu, a.lu);
            compare("left_down_duty", e.ld, a.ld);
            compare("busy_res", e.busy, a.busy);
            compare("job_done", e.done, a.done);
            compare("found_limit", e.found, a.found);
            compare("position_right", e.pos_r, a.pos_r);
            compare("position_left", e.pos_l, a.pos_l);
            compare("bad_command", e.bad, a.bad);
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                cfg_we;
    logic [CFG_A_W-1:0]  cfg_index;
    logic [CFG_W-1:0]    cfg_data;

    lpc_in_if  cmd_if ();
    lpc_out_if res_if ();

    two_channel_lid_position_controller i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data),
        .i_cmd      (cmd_if),
        .o_res      (res_if)
    );

    lid_drive_scoreboard sb;
    int                  beats_sent;
    int                  beats_noted;
    int                  live_items;
    int                  snd_idle;
    int                  rcv_idle;
    int                  hold_asks;
    int                  holds_done;
    int                  hold_left;
    int                  cur_s[2];

    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    initial begin
        #4000000;
        $display("status: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        t_lid_beat     b;
        t_drive_report a;
        if (i_rst_n) begin
            if (res_if.valid && res_if.ready) begin
                a.ru    = res_if.right_up_duty;
                a.rd    = res_if.right_down_duty;
                a.lu    = res_if.left_up_duty;
                a.ld    = res_if.left_down_duty;
                a.busy  = res_if.busy_res;
                a.done  = res_if.job_done;
                a.found = res_if.found_limit;
                a.pos_r = $signed(res_if.position_right);
                a.pos_l = $signed(res_if.position_left);
                a.bad   = res_if.bad_command;
                sb.check_drive(a);
            end
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if (cmd_if.valid && cmd_if.ready) begin
                b.op    = cmd_if.operation;
                b.ch    = cmd_if.channel;
                b.dir   = cmd_if.direction;
                b.tgt   = cmd_if.target_percent;
                b.spd   = cmd_if.drive_speed;
                b.smp_r = cmd_if.sample_right;
                b.smp_l = cmd_if.sample_left;
                sb.note_command(b);
                beats_noted++;
            end
        end
    end

    initial begin
        res_if.ready = 1'b0;
        hold_left    = 0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != holds_done) begin
                holds_done++;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= rcv_idle);
            end
        end
    end

    function automatic int clamp_adc(int v);
        return (v < 0) ? 0 : ((v > ADC_TOP) ? ADC_TOP : v);
    endfunction

    task automatic send_beat(input logic [1:0] op, input logic [1:0] ch, input logic dir,
                             input int tgt, input int spd, input int sr, input int sl);
        while ($urandom_range(0, 99) < snd_idle) begin
            cmd_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        if (op == OP_FIND || op == OP_MOVE || (op == OP_TICK && sb.mode != MODE_IDLE))
            live_items++;
        cmd_if.valid          <= 1'b1;
        cmd_if.operation      <= op;
        cmd_if.channel        <= ch;
        cmd_if.direction      <= dir;
        cmd_if.target_percent <= tgt[PCT_W-1:0];
        cmd_if.drive_speed    <= spd[SPD_W-1:0];
        cmd_if.sample_right   <= sr[9:0];
        cmd_if.sample_left    <= sl[9:0];
        beats_sent++;
        @(posedge i_clk);
        while (!cmd_if.ready)
            @(posedge i_clk);
        wait (beats_noted == beats_sent);
        cur_s[0] = sr;
        cur_s[1] = sl;
    endtask

    task automatic tick(input int sr, input int sl);
        send_beat(OP_TICK, 2'($urandom_range(0, 2)), 1'($urandom_range(0, 1)),
                  $urandom_range(0, 100), $urandom_range(0, 255), sr, sl);
    endtask

    task automatic tick_on(input int c, input int s);
        int o;
        o = clamp_adc(cur_s[1 - c] + $urandom_range(0, 4) - 2);
        if (c == 0)
            tick(s, o);
        else
            tick(o, s);
    endtask

    task automatic noise_beat();
        send_beat(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                  1'($urandom_range(0, 1)), $urandom_range(0, 100), $urandom_range(0, 255),
                  $urandom_range(0, ADC_TOP), $urandom_range(0, ADC_TOP));
    endtask

    task automatic set_config(input int tol, input int lim, input int db, input int spd);
        cmd_if.valid <= 1'b0;
        while (!sb.empty())
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_index <= REG_TOL;
        cfg_data  <= tol[CFG_W-1:0];
        @(posedge i_clk);
        cfg_index <= REG_LIMIT;
        cfg_data  <= lim[CFG_W-1:0];
        @(posedge i_clk);
        cfg_index <= REG_DBAND;
        cfg_data  <= db[CFG_W-1:0];
        @(posedge i_clk);
        cfg_index <= REG_SPEED;
        cfg_data  <= spd[CFG_W-1:0];
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic find_run(input int c, input logic dir);
        int goal;
        int s;
        int stepv;
        int guard;
        goal = dir ? $urandom_range(600, ADC_TOP) : $urandom_range(0, 400);
        if ($urandom_range(0, 5) == 0)
            goal = dir ? ADC_TOP : 0;
        send_beat(OP_FIND, 2'(c), dir, $urandom_range(0, 100), $urandom_range(0, 255),
                  cur_s[0], cur_s[1]);
        s = cur_s[c];
        repeat ($urandom_range(0, 4)) begin
            stepv = sb.tol + 1 + $urandom_range(0, 40);
            if (goal > s)
                s = (s + stepv > goal) ? goal : s + stepv;
            else
                s = (s - stepv < goal) ? goal : s - stepv;
            tick_on(c, s);
        end
        guard = 0;
        while (sb.mode == MODE_FIND && guard < sb.still_limit + 20) begin
            if ($urandom_range(0, 24) == 0)
                noise_beat();
            else
                tick_on(c, goal);
            guard++;
        end
    endtask

    task automatic move_run(input logic [1:0] ch);
        int tgt;
        int goal[2];
        int ns[2];
        int d;
        int k;
        int guard;
        tgt = $urandom_range(0, 100);
        if ($urandom_range(0, 7) == 0)
            tgt = $urandom_range(0, 1) * 100;
        send_beat(OP_MOVE, ch, 1'($urandom_range(0, 1)), tgt, $urandom_range(0, 255),
                  cur_s[0], cur_s[1]);
        for (k = 0; k < 2; k++)
            goal[k] = clamp_adc(sb.lower_stop[k] +
                                (sb.upper_stop[k] - sb.lower_stop[k]) * tgt / 100);
        guard = 0;
        while (sb.mode == MODE_MOVE && guard < 16) begin
            for (k = 0; k < 2; k++) begin
                d = goal[k] - cur_s[k];
                if (d >= -2 && d <= 2)
                    ns[k] = goal[k];
                else
                    ns[k] = clamp_adc(cur_s[k] + d / 2 + $urandom_range(0, 2) - 1);
            end
            tick(ns[0], ns[1]);
            guard++;
        end
    endtask

    task automatic random_sequence();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 30)
            find_run($urandom_range(0, 1), 1'($urandom_range(0, 1)));
        else if (pick < 80)
            move_run(2'($urandom_range(0, 2)));
        else
            repeat ($urandom_range(1, 4)) noise_beat();
    endtask

    initial begin
        int n;
        int goal_items;
        int held;
        sb                    = new();
        i_rst_n               = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = REG_TOL;
        cfg_data              = '0;
        cmd_if.valid          = 1'b0;
        cmd_if.operation      = OP_TICK;
        cmd_if.channel        = CH_RIGHT;
        cmd_if.direction      = 1'b0;
        cmd_if.target_percent = '0;
        cmd_if.drive_speed    = '0;
        cmd_if.sample_right   = '0;
        cmd_if.sample_left    = '0;
        beats_sent            = 0;
        beats_noted           = 0;
        live_items            = 0;
        hold_asks             = 0;
        holds_done            = 0;
        cur_s                 = '{0, 0};
        snd_idle              = 35;
        rcv_idle              = 50;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        tick(0, ADC_TOP);
        send_beat(OP_SPARE, CH_NONE, 1'b1, 100, 255, ADC_TOP, 0);
        send_beat(OP_FIND, CH_BOTH, 1'b1, 0, 0, 10, 10);
        send_beat(OP_FIND, CH_NONE, 1'b0, 0, 0, 10, 10);
        send_beat(OP_MOVE, CH_NONE, 1'b0, 50, 100, 10, 10);
        send_beat(OP_FIND, CH_RIGHT, 1'b0, 0, 0, 5, 900);
        repeat (5) tick(0, 900);
        send_beat(OP_FIND, CH_RIGHT, 1'b1, 0, 0, ADC_TOP, 900);
        repeat (5) tick(ADC_TOP, 900);
        send_beat(OP_MOVE, CH_BOTH, 1'b0, 100, 255, ADC_TOP, 500);
        tick(ADC_TOP, 500);
        send_beat(OP_FIND, CH_LEFT, 1'b1, 0, 0, ADC_TOP, ADC_TOP);
        set_config(TOL_RST, 0, DBAND_RST, SPEED_RST);
        tick(ADC_TOP, ADC_TOP);
        send_beat(OP_MOVE, CH_RIGHT, 1'b0, 0, 7, 0, ADC_TOP);
        tick(0, ADC_TOP);

        for (n = 0; n < PHASES; n++) begin
            case (n / 4)
                0: begin
                    snd_idle = 35;
                    rcv_idle = 50;
                end
                1: begin
                    snd_idle = 50;
                    rcv_idle = 35;
                end
                default: begin
                    snd_idle = 0;
                    rcv_idle = 0;
                end
            endcase
            if (n == 0)
                set_config(0, 1, 0, 0);
            else if (n == 1)
                set_config(ADC_TOP, 255, 100, 255);
            else
                set_config(($urandom_range(0, 3) == 0) ? $urandom_range(0, ADC_TOP)
                                                        : $urandom_range(0, 12),
                           ($urandom_range(0, 7) == 0) ? $urandom_range(1, 60)
                                                        : $urandom_range(1, 12),
                           $urandom_range(0, 1) ? $urandom_range(0, 20)
                                                : $urandom_range(0, 100),
                           $urandom_range(0, 255));
            goal_items = live_items + ITEMS / PHASES;
            held       = 0;
            while (live_items < goal_items) begin
                if (n % 4 == 2 && held == 0 &&
                    live_items + ITEMS / PHASES / 2 >= goal_items) begin
                    hold_asks++;
                    held = 1;
                end
                random_sequence();
            end
        end

        cmd_if.valid <= 1'b0;
        while (!sb.empty())
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.empty())
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

[sim.f]
rtl/core/lpc_pkg.sv
rtl/core/lpc_in_if.sv
rtl/core/lpc_out_if.sv
rtl/core/lpc_map.sv
rtl/core/lpc_ctrl.sv
rtl/core/two_channel_lid_position_controller.sv
sim/tb.sv
